@@ hdl/gtmu_pkg.sv @@
// Shared constants, field layout and controller/datapath interface types for the GEMM tile core.
package gtmu_pkg;

    localparam int TILE_ROWS    = 4;
    localparam int TILE_COLS    = 4;
    localparam int TILE_N       = TILE_ROWS * TILE_COLS;
    localparam int ACC_BITS_DEF = 48;

    localparam int Q_W   = 16;   // A, B, alpha, beta
    localparam int C_W   = 32;   // C element and result
    localparam int IDX_W = $clog2(TILE_N);

    // beta*C sits at Q.44 once shifted, alpha*acc at Q.44; result is Q.15
    localparam int C_SHIFT   = 15;
    localparam int RND_SHIFT = 29;

    // s_tdata layout, lowest bits first
    localparam int A_LSB       = 0;
    localparam int B_LSB       = A_LSB + TILE_ROWS * Q_W;
    localparam int C_LSB       = B_LSB + TILE_COLS * Q_W;
    localparam int IDX_LSB     = C_LSB + C_W;
    localparam int S_FIELDS_W  = IDX_LSB + IDX_W;
    localparam int S_TDATA_W   = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int S_TUSER_W   = 2;
    localparam int USER_ACTION = 0;
    localparam int USER_FIRST  = 1;

    localparam int M_TDATA_W = C_W;
    localparam int M_TUSER_W = 1;

    localparam logic ACT_ACC = 1'b0;
    localparam logic ACT_UPD = 1'b1;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = Q_W;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BETA  = 8'd1;

    localparam logic [Q_W-1:0] ALPHA_RST = 16'h4000;
    localparam logic [Q_W-1:0] BETA_RST  = 16'h0000;

    typedef struct packed {
        logic ld_acc;   // capture products of an accumulate word
        logic add_acc;  // fold products into the accumulators
        logic ld_upd;   // capture C and the selected accumulator
        logic mul;      // form the three scaled partial products
        logic sum;      // add low terms, round and shift
        logic ld_out;   // final add, saturate, load output register
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } stat_t;

endpackage

@@ hdl/gtmu_ctrl.sv @@
// Sequencing state machine for accumulate and update words.
module gtmu_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic              action,
    input  gtmu_pkg::stat_t   stat,
    output gtmu_pkg::cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_ACC  = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_SUM  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (action == gtmu_pkg::ACT_UPD) begin
                        cmd.ld_upd = 1'b1;
                        state_next = ST_MUL;
                    end else begin
                        cmd.ld_acc = 1'b1;
                        state_next = ST_ACC;
                    end
                end
            end
            ST_ACC: begin
                cmd.add_acc = 1'b1;
                state_next  = ST_IDLE;
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM: begin
                cmd.sum    = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                // hold the result until the output register frees up
                if (stat.out_free) begin
                    cmd.ld_out = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ hdl/gtmu_datapath.sv @@
// Product lanes, tile accumulators, scaling pipeline and output register.
module gtmu_datapath #(
    parameter int ACC_BITS = gtmu_pkg::ACC_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  gtmu_pkg::cmd_t                      cmd,
    output gtmu_pkg::stat_t                     stat,
    input  logic [gtmu_pkg::S_TDATA_W-1:0]      s_tdata,
    input  logic [gtmu_pkg::S_TUSER_W-1:0]      s_tuser,
    input  logic                                cfg_we,
    input  logic [gtmu_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [gtmu_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [gtmu_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic [gtmu_pkg::M_TUSER_W-1:0]      m_tuser
);

    localparam int Q_W    = gtmu_pkg::Q_W;
    localparam int C_W    = gtmu_pkg::C_W;
    localparam int N      = gtmu_pkg::TILE_N;
    localparam int ROWS   = gtmu_pkg::TILE_ROWS;
    localparam int COLS   = gtmu_pkg::TILE_COLS;
    localparam int PROD_W = 2 * Q_W;
    localparam int LO_W   = gtmu_pkg::RND_SHIFT;
    localparam int HI_W   = ACC_BITS - LO_W;
    localparam int PLO_W  = Q_W + LO_W + 1;
    localparam int PHI_W  = Q_W + HI_W;
    localparam int PC_W   = Q_W + C_W;
    localparam int PART_W = PC_W + gtmu_pkg::C_SHIFT + 1;
    localparam int PSH_W  = PART_W - gtmu_pkg::RND_SHIFT;
    localparam int TOT_W  = ((PHI_W > PSH_W) ? PHI_W : PSH_W) + 1;

    // configuration
    logic signed [Q_W-1:0] alpha_reg;
    logic signed [Q_W-1:0] beta_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_reg <= gtmu_pkg::ALPHA_RST;
            beta_reg  <= gtmu_pkg::BETA_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                gtmu_pkg::CFG_ALPHA: alpha_reg <= cfg_data;
                gtmu_pkg::CFG_BETA:  beta_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // outer-product lanes, slot = row + ROWS*col
    logic signed [Q_W-1:0]    a_vec  [ROWS];
    logic signed [Q_W-1:0]    b_vec  [COLS];
    logic signed [PROD_W-1:0] prod_w [N];
    logic signed [PROD_W-1:0] prod_reg [N];
    logic                     first_reg;

    for (genvar i = 0; i < ROWS; i++) begin : g_a
        assign a_vec[i] = s_tdata[gtmu_pkg::A_LSB + i*Q_W +: Q_W];
    end
    for (genvar j = 0; j < COLS; j++) begin : g_b
        assign b_vec[j] = s_tdata[gtmu_pkg::B_LSB + j*Q_W +: Q_W];
    end
    for (genvar j = 0; j < COLS; j++) begin : g_col
        for (genvar i = 0; i < ROWS; i++) begin : g_row
            assign prod_w[i + j*ROWS] = a_vec[i] * b_vec[j];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.ld_acc) begin
            prod_reg  <= prod_w;
            first_reg <= s_tuser[gtmu_pkg::USER_FIRST];
        end
    end

    logic signed [ACC_BITS-1:0] acc_reg [N];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < N; k++) begin
                acc_reg[k] <= '0;
            end
        end else if (cmd.add_acc) begin
            for (int k = 0; k < N; k++) begin
                acc_reg[k] <= (first_reg ? ACC_BITS'(0) : acc_reg[k])
                            + {{(ACC_BITS-PROD_W){prod_reg[k][PROD_W-1]}}, prod_reg[k]};
            end
        end
    end

    // update pipeline
    logic signed [ACC_BITS-1:0] sel_acc_reg;
    logic signed [C_W-1:0]      c_reg;
    logic [gtmu_pkg::IDX_W-1:0] idx_w;

    assign idx_w = s_tdata[gtmu_pkg::IDX_LSB +: gtmu_pkg::IDX_W];

    always_ff @(posedge aclk) begin
        if (cmd.ld_upd) begin
            sel_acc_reg <= acc_reg[idx_w];
            c_reg       <= s_tdata[gtmu_pkg::C_LSB +: C_W];
        end
    end

    logic signed [LO_W:0]     lo_s;
    logic signed [HI_W-1:0]   hi_s;
    logic signed [PLO_W-1:0]  mul_lo;
    logic signed [PHI_W-1:0]  mul_hi;
    logic signed [PC_W-1:0]   mul_c;
    logic signed [PLO_W-1:0]  p_lo_reg;
    logic signed [PHI_W-1:0]  p_hi_reg;
    logic signed [PC_W-1:0]   p_c_reg;

    // split the accumulator so each multiply stays narrow
    assign lo_s   = {1'b0, sel_acc_reg[LO_W-1:0]};
    assign hi_s   = sel_acc_reg[ACC_BITS-1:LO_W];
    assign mul_lo = alpha_reg * lo_s;
    assign mul_hi = alpha_reg * hi_s;
    assign mul_c  = beta_reg * c_reg;

    always_ff @(posedge aclk) begin
        if (cmd.mul) begin
            p_lo_reg <= mul_lo;
            p_hi_reg <= mul_hi;
            p_c_reg  <= mul_c;
        end
    end

    logic signed [PART_W-1:0] part_w;
    logic signed [PSH_W-1:0]  part_reg;

    assign part_w = PART_W'(p_lo_reg)
                  + (PART_W'(p_c_reg) <<< gtmu_pkg::C_SHIFT)
                  + (PART_W'(1) <<< (gtmu_pkg::RND_SHIFT - 1));

    always_ff @(posedge aclk) begin
        if (cmd.sum) begin
            part_reg <= part_w[PART_W-1:gtmu_pkg::RND_SHIFT];
        end
    end

    logic signed [TOT_W-1:0] total_w;
    logic [TOT_W-C_W:0]      top_bits;
    logic                    sat_w;
    logic [C_W-1:0]          res_w;

    assign total_w  = TOT_W'(p_hi_reg) + TOT_W'(part_reg);
    assign top_bits = total_w[TOT_W-1:C_W-1];
    assign sat_w    = !((&top_bits) || !(|top_bits));
    assign res_w    = !sat_w ? total_w[C_W-1:0]
                    : (total_w[TOT_W-1] ? {1'b1, {(C_W-1){1'b0}}}
                                        : {1'b0, {(C_W-1){1'b1}}});

    // output register
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [C_W-1:0]        out_data_reg;
    logic                  out_sat_reg;

    assign stat.out_free  = !out_valid_reg || m_tready;
    assign out_valid_next = cmd.ld_out || (out_valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.ld_out) begin
            out_data_reg <= res_w;
            out_sat_reg  <= sat_w;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_sat_reg;

endmodule

@@ hdl/gemm_tile_4x4_mac_update_core.sv @@
// Top level of the 4x4 GEMM micro-tile core: controller plus datapath.
// Accumulate word: the next word is taken once the product stage and the accumulator add are done.
// Update word: operand, product and sum registers feed the output register; the next word is
// taken once the result is loaded, later while a previous result is still unread there.
// Throughput is set by the single shared scaling pipeline (multiply, round, saturate).
// aresetn is synchronous, active low: clears accumulators, alpha to 1.0, beta to 0, outputs idle.
module gemm_tile_4x4_mac_update_core #(
    parameter int ACC_BITS = gtmu_pkg::ACC_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // a_row0..a_row3, b_col0..b_col3, c_value, tile_index, zero pad
    input  logic [gtmu_pkg::S_TDATA_W-1:0]      s_tdata,
    // action, first_step
    input  logic [gtmu_pkg::S_TUSER_W-1:0]      s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // c_result
    output logic [gtmu_pkg::M_TDATA_W-1:0]      m_tdata,
    // saturated
    output logic [gtmu_pkg::M_TUSER_W-1:0]      m_tuser,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [gtmu_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [gtmu_pkg::CFG_DATA_W-1:0]     cfg_data
);

    gtmu_pkg::cmd_t  cmd;
    gtmu_pkg::stat_t stat;

    assign cfg_ready = 1'b1;

    gtmu_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .action   (s_tuser[gtmu_pkg::USER_ACTION]),
        .stat     (stat),
        .cmd      (cmd)
    );

    gtmu_datapath #(
        .ACC_BITS (ACC_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

@@ hdl/gtmu_checker.sv @@
// Port-level checks for the GEMM tile core, bound to the top level.
module gtmu_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_tvalid,
    input logic                                s_tready,
    input logic [gtmu_pkg::S_TUSER_W-1:0]      s_tuser,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [gtmu_pkg::M_TDATA_W-1:0]      m_tdata,
    input logic [gtmu_pkg::M_TUSER_W-1:0]      m_tuser
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    a_rst_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid straight after reset");

    // an update word occupies the scaling pipeline
    a_upd_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser[gtmu_pkg::USER_ACTION] == gtmu_pkg::ACT_UPD)
        |=> !s_tready)
        else $error("input taken while an update is in flight");

    a_acc_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser[gtmu_pkg::USER_ACTION] == gtmu_pkg::ACT_ACC)
        |=> !$rose(m_tvalid))
        else $error("accumulate word produced a result");

    a_sat_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> (m_tdata == 32'h7FFF_FFFF) || (m_tdata == 32'h8000_0000))
        else $error("saturated flag on an unclipped value");

endmodule

bind gemm_tile_4x4_mac_update_core gtmu_checker u_gtmu_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
